// ===== rtl/fcr_pkg.sv =====
// Shared types, constants and the CRC byte step for the frame reassembly block.
`default_nettype none

package fcr_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [7:0]  POS_MAX  = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO = 8'h00;
  localparam int unsigned COUNT_SAT = 65535;

  typedef enum logic {
    CMD_PAYLOAD = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_CRC_FAIL  = 3'd2,
    ST_BAD_FRAME = 3'd3,
    ST_READ      = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] frame_id;
    logic [31:0] stored_crc;
    logic [7:0]  payload_byte;
    logic        end_of_frame;
    logic [16:0] read_address;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        read_in_range;
    logic [9:0]  highest_frame_id;
    logic [10:0] frames_accepted;
    logic [15:0] frames_duplicate;
    logic [15:0] frames_failed;
    logic [10:0] missing_frames;
  } out_item_t;

  // Control of the running CRC register
  typedef struct packed {
    logic       seed;
    logic       step;
    logic [7:0] data;
  } crc_ctl_t;

  // Reflected CRC-32, one byte, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fcr_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface fcr_in_if;
  logic              valid;
  logic              ready;
  fcr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcr_out_if;
  logic               valid;
  logic               ready;
  fcr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/fcr_crc.sv =====
// Running reflected CRC-32 register with seed, byte step and checksum compare.
`default_nettype none

module fcr_crc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fcr_pkg::crc_ctl_t ctl_i,
  input  wire logic [31:0]       expect_i,
  output logic                   match_o
);

  logic [31:0] crc_q;
  logic [31:0] crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.seed) begin
      crc_d = fcr_pkg::CRC_ONES;
    end else if (ctl_i.step) begin
      crc_d = fcr_pkg::crc_byte(crc_q, ctl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= fcr_pkg::CRC_ONES;
    end else begin
      crc_q <= crc_d;
    end
  end

  // final value is the register inverted
  assign match_o = ((crc_q ^ fcr_pkg::CRC_ONES) == expect_i);

endmodule

`default_nettype wire

// ===== rtl/frame_crc_reassembly.sv =====
// Top level: CRC-checked frame reassembly into a byte store with per-frame valid bits.
// Payload byte: IDLE, then BYTE (CRC step, store write); a frame's first byte first folds its
// 4 id bytes into the CRC in SEED. Last byte: EVAL, then OUT. Read: RDIV, RMEM, RRES.
// Rate is set by the single byte-wide CRC step and the registered read of the two RAMs.
// After reset the valid-bit RAM is swept to zero with input held off.
// Results wait in an output register; the next transaction is taken once it is free or taken.
`default_nettype none

module frame_crc_reassembly #(
  parameter int unsigned FRAME_BYTES = 128,
  parameter int unsigned MAX_FRAMES  = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fcr_in_if.sink    in_i,
  fcr_out_if.source out_o
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int unsigned STORE_BYTES = MAX_FRAMES * FRAME_BYTES;
  localparam int unsigned VB_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned SA_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned LIM_W = VB_W + 9;
  // address / FRAME_BYTES as multiply by a rounded-up reciprocal; exact for
  // 17-bit addresses as the rounding error times the address stays below 2^25
  localparam int unsigned DIV_SH = 25;
  localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + FRAME_BYTES - 1) / FRAME_BYTES;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEED,
    S_BYTE,
    S_EVAL,
    S_OUT,
    S_RDIV,
    S_RMEM,
    S_RRES
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e               state_q;
  fcr_pkg::in_item_t    item_q;        // transaction under work
  logic [VB_W-1:0]      clr_q;         // clearing sweep pointer
  logic [1:0]           seed_cnt_q;    // id byte being folded into the CRC
  logic [7:0]           pos_q;         // byte position within the frame
  logic [31:0]          cur_id_q;
  logic                 id_ok_q;
  logic                 cur_valid_q;   // slot of the current frame already valid
  logic [SA_W-1:0]      base_q;        // store address of byte 0 of the frame
  fcr_pkg::status_e     status_q;
  logic [VB_W-1:0]      highest_q;
  logic [10:0]          acc_cnt_q;
  logic [15:0]          dup_cnt_q;
  logic [15:0]          fail_cnt_q;
  logic [VB_W-1:0]      fr_q;          // frame index of a read address
  logic                 fr_ok_q;
  logic [LIM_W-1:0]     limit_q;
  logic                 out_valid_q;
  fcr_pkg::out_item_t   out_data_q;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_fire;
  assign in_i.ready  = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------------------------------------------------------------------
  // CRC unit
  // ---------------------------------------------------------------------------
  fcr_pkg::crc_ctl_t crc_ctl;
  logic              crc_match;

  always_comb begin
    crc_ctl.seed = in_fire && (in_i.data.command == fcr_pkg::CMD_PAYLOAD)
                   && (pos_q == 8'd0);
    crc_ctl.step = (state_q == S_SEED) || (state_q == S_BYTE);
    // id bytes most significant first, then the payload byte
    crc_ctl.data = (state_q == S_SEED) ? cur_id_q[8*(3-seed_cnt_q) +: 8]
                                       : item_q.payload_byte;
  end

  fcr_crc u_crc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (crc_ctl),
    .expect_i (item_q.stored_crc),
    .match_o  (crc_match)
  );

  // ---------------------------------------------------------------------------
  // Valid-bit RAM: cleared by a sweep, set when a frame is accepted
  // ---------------------------------------------------------------------------
  logic            vb_we;
  logic [VB_W-1:0] vb_waddr;
  logic            vb_wdata;
  logic [VB_W-1:0] vb_raddr;
  logic            vb_rdata;
  logic [VB_W-1:0] cur_idx;
  logic            accept_frame;

  assign cur_idx  = cur_id_q[VB_W-1:0];
  assign vb_we    = (state_q == S_CLEAR) || ((state_q == S_EVAL) && accept_frame);
  assign vb_waddr = (state_q == S_CLEAR) ? clr_q : cur_idx;
  assign vb_wdata = (state_q != S_CLEAR);
  assign vb_raddr = (state_q == S_SEED) ? cur_idx : fr_q;

  fcr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FRAMES)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vb_we),
    .waddr_i (vb_waddr),
    .wdata_i (vb_wdata),
    .raddr_i (vb_raddr),
    .rdata_o (vb_rdata)
  );

  // ---------------------------------------------------------------------------
  // Byte store: written while a frame streams in, never for a valid slot
  // ---------------------------------------------------------------------------
  logic            st_we;
  logic [SA_W-1:0] st_waddr;
  logic [SA_W-1:0] st_raddr;
  logic [7:0]      st_rdata;
  logic [31:0]     rd_addr_ext;

  assign st_we = (state_q == S_BYTE) && id_ok_q && !cur_valid_q
                 && ({1'b0, pos_q} < 9'(FRAME_BYTES));
  assign st_waddr    = base_q + SA_W'(pos_q);
  assign rd_addr_ext = 32'(item_q.read_address);
  assign st_raddr    = rd_addr_ext[SA_W-1:0];

  fcr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (item_q.payload_byte),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // Arithmetic between registers
  // ---------------------------------------------------------------------------
  logic [42:0]        div_prod;
  logic [VB_W+7:0]    base_full;
  logic [LIM_W-1:0]   limit_d;
  logic               len_ok;
  logic [31:0]        hid_ext;
  logic [16:0]        span;
  logic [16:0]        missing;
  fcr_pkg::out_item_t common;

  assign div_prod  = 43'(item_q.read_address) * 43'(RECIP);
  assign base_full = (VB_W+8)'(cur_idx) * (VB_W+8)'(FRAME_BYTES);
  assign limit_d   = (LIM_W'(highest_q) + LIM_W'(1)) * LIM_W'(FRAME_BYTES);
  assign len_ok    = (({1'b0, pos_q} + 9'd1) == 9'(FRAME_BYTES));
  assign accept_frame = id_ok_q && len_ok && crc_match && !cur_valid_q;

  // Fields every result carries, from the current state
  always_comb begin
    hid_ext = 32'(highest_q);
    span    = 17'(highest_q) + 17'd1;
    missing = (span > 17'(acc_cnt_q)) ? (span - 17'(acc_cnt_q)) : 17'd0;
    common  = '0;
    common.highest_frame_id = hid_ext[9:0];
    common.frames_accepted  = acc_cnt_q;
    common.frames_duplicate = dup_cnt_q;
    common.frames_failed    = fail_cnt_q;
    common.missing_frames   = missing[10:0];
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'(fcr_pkg::COUNT_SAT)) ? v : v + 16'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      seed_cnt_q  <= '0;
      pos_q       <= '0;
      cur_id_q    <= '0;
      id_ok_q     <= 1'b0;
      cur_valid_q <= 1'b0;
      status_q    <= fcr_pkg::ST_ACCEPTED;
      highest_q   <= '0;
      acc_cnt_q   <= '0;
      dup_cnt_q   <= '0;
      fail_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + VB_W'(1);
          if (clr_q == VB_W'(MAX_FRAMES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            item_q <= in_i.data;
            if (in_i.data.command == fcr_pkg::CMD_READ) begin
              state_q <= S_RDIV;
            end else if (pos_q == 8'd0) begin
              cur_id_q   <= in_i.data.frame_id;
              id_ok_q    <= (in_i.data.frame_id < 32'(MAX_FRAMES));
              seed_cnt_q <= '0;
              state_q    <= S_SEED;
            end else begin
              state_q <= S_BYTE;
            end
          end
        end
        S_SEED: begin
          // slot read issued on the first id byte, data back on the second
          seed_cnt_q <= seed_cnt_q + 2'd1;
          base_q     <= base_full[SA_W-1:0];
          if (seed_cnt_q == 2'd1) begin
            cur_valid_q <= vb_rdata;
          end
          if (seed_cnt_q == 2'd3) begin
            state_q <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (item_q.end_of_frame) begin
            state_q <= S_EVAL;
          end else begin
            pos_q   <= (pos_q == fcr_pkg::POS_MAX) ? pos_q : pos_q + 8'd1;
            state_q <= S_IDLE;
          end
        end
        S_EVAL: begin
          // bad id or length, then checksum, then duplicate
          if (!id_ok_q || !len_ok) begin
            status_q   <= fcr_pkg::ST_BAD_FRAME;
            fail_cnt_q <= sat_inc(fail_cnt_q);
          end else if (!crc_match) begin
            status_q   <= fcr_pkg::ST_CRC_FAIL;
            fail_cnt_q <= sat_inc(fail_cnt_q);
          end else if (cur_valid_q) begin
            status_q  <= fcr_pkg::ST_DUPLICATE;
            dup_cnt_q <= sat_inc(dup_cnt_q);
          end else begin
            status_q <= fcr_pkg::ST_ACCEPTED;
            if (cur_idx > highest_q) begin
              highest_q <= cur_idx;
            end
            if (acc_cnt_q != 11'h7FF) begin
              acc_cnt_q <= acc_cnt_q + 11'd1;
            end
          end
          pos_q   <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q       <= 1'b1;
          out_data_q        <= common;
          out_data_q.status <= status_q;
          state_q           <= S_IDLE;
        end
        S_RDIV: begin
          fr_q    <= div_prod[DIV_SH +: VB_W];
          fr_ok_q <= (rd_addr_ext < 32'(STORE_BYTES));
          limit_q <= limit_d;
          state_q <= S_RMEM;
        end
        S_RMEM: begin
          state_q <= S_RRES;
        end
        S_RRES: begin
          out_valid_q              <= 1'b1;
          out_data_q               <= common;
          out_data_q.status        <= fcr_pkg::ST_READ;
          out_data_q.read_valid    <= fr_ok_q && vb_rdata;
          out_data_q.read_byte     <= (fr_ok_q && vb_rdata) ? st_rdata : fcr_pkg::BYTE_ZERO;
          out_data_q.read_in_range <= (rd_addr_ext < 32'(limit_q));
          state_q                  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
